[src/stp_pkg.sv]
// Shared types, constants and the half-step table for the stepper sequencer.
// No dependencies; used by every module of the block.
package stp_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int STEP_W = 16;
	localparam int COIL_W = 4;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef logic [COIL_W-1:0] coil_t;
	typedef logic signed [1:0] dir_t;

	typedef struct packed {
		coil_t coil_pattern;
		logic drive_enabled;
		logic pattern_written;
		logic running;
		logic move_done;
	} res_t;

	function automatic coil_t half_step(input logic [2:0] phase);
		coil_t pat;
		case (phase)
			3'd0: pat = 4'd1;
			3'd1: pat = 4'd3;
			3'd2: pat = 4'd2;
			3'd3: pat = 4'd6;
			3'd4: pat = 4'd4;
			3'd5: pat = 4'd12;
			3'd6: pat = 4'd8;
			3'd7: pat = 4'd9;
			default: pat = 4'd0;
		endcase
		return pat;
	endfunction

endpackage

[src/stepper_half_step_round_trip.sv]
// Half-step stepper sequencer with a return pass. A request is either a tick or a start
// with a signed step count. The block takes one request per clock cycle while results
// are taken, and answers every request with exactly one result. A request is held in the
// input register, is worked on by the sequencer logic and moves into the result register
// when that register is free or its result is being taken; the result is then offered.
// Throughput is one request per cycle when the output does not stall, limited only by the
// single sequencer state update per cycle; the result register lets the next request in
// while a result waits to be taken. COUNT_BITS sets the step counter width.
// Depends on stp_pkg and stp_core.
module stepper_half_step_round_trip #(
	parameter int COUNT_BITS = stp_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              action,
	input  logic signed [stp_pkg::STEP_W-1:0] step_count,
	output logic                              res_valid,
	input  logic                              res_ready,
	output stp_pkg::coil_t                    coil_pattern,
	output logic                              drive_enabled,
	output logic                              pattern_written,
	output logic                              running,
	output logic                              move_done
);

	logic                              valid_s1;
	logic                              action_s1;
	logic signed [stp_pkg::STEP_W-1:0] count_s1;
	logic                              res_valid_q;
	stp_pkg::res_t                     res_q;
	stp_pkg::res_t                     res_d;
	logic                              adv;

	assign adv = valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			action_s1 <= action;
			count_s1 <= step_count;
		end
	end

	stp_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(adv),
		.action(action_s1),
		.step_count(count_s1),
		.res(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign coil_pattern = res_q.coil_pattern;
	assign drive_enabled = res_q.drive_enabled;
	assign pattern_written = res_q.pattern_written;
	assign running = res_q.running;
	assign move_done = res_q.move_done;

endmodule

[src/stp_core.sv]
// Sequencer state and its combinational update for one request.
// Depends on stp_pkg.
module stp_core #(
	parameter int COUNT_BITS = stp_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        action,
	input  logic signed [stp_pkg::STEP_W-1:0] step_count,
	output stp_pkg::res_t               res
);

	localparam int WB = (COUNT_BITS > stp_pkg::STEP_W) ? COUNT_BITS : stp_pkg::STEP_W;
	localparam logic [WB-1:0] LIM = WB'((64'd1 << COUNT_BITS) - 64'd2);

	logic                  busy_q, returning_q, drivers_q;
	logic [2:0]            phase_q;
	logic [COUNT_BITS-1:0] step_q, target_q;
	stp_pkg::dir_t         dir_q;
	stp_pkg::coil_t        coil_q;

	logic                  busy_d, returning_d, drivers_d;
	logic [2:0]            phase_d;
	logic [COUNT_BITS-1:0] step_d, target_d;
	stp_pkg::dir_t         dir_d;
	stp_pkg::coil_t        coil_d;
	logic                  written, done;

	logic [stp_pkg::STEP_W-1:0] mag16;
	logic [WB-1:0]              mag_w, mag_sat;

	always_comb begin
		// magnitude of the signed count; the most negative value gives 2^15
		mag16 = step_count[stp_pkg::STEP_W-1] ? stp_pkg::STEP_W'(-step_count)
			: stp_pkg::STEP_W'(step_count);
		mag_w = WB'(mag16);
		mag_sat = (mag_w > LIM) ? LIM : mag_w;
	end

	always_comb begin
		busy_d = busy_q;
		returning_d = returning_q;
		drivers_d = drivers_q;
		phase_d = phase_q;
		step_d = step_q;
		target_d = target_q;
		dir_d = dir_q;
		coil_d = coil_q;
		written = 1'b0;
		done = 1'b0;
		if (action == stp_pkg::ACT_START) begin
			if (!busy_q) begin
				if (step_count[stp_pkg::STEP_W-1])
					dir_d = -2'sd1;
				else if (step_count != '0)
					dir_d = 2'sd1;
				else
					dir_d = 2'sd0;
				busy_d = 1'b1;
				returning_d = 1'b0;
				step_d = '0;
				target_d = mag_sat[COUNT_BITS-1:0];
				drivers_d = 1'b1;
			end
		end else if (busy_q) begin
			if (step_q <= target_q) begin
				coil_d = stp_pkg::half_step(phase_q);
				written = 1'b1;
				// direction sign-extended to 3 bits: -1 steps back modulo 8
				phase_d = phase_q + {dir_q[1], dir_q};
				step_d = step_q + COUNT_BITS'(1);
			end else if (!returning_q) begin
				step_d = '0;
				phase_d = '0;
				dir_d = 2'(-dir_q);
				returning_d = 1'b1;
			end else begin
				busy_d = 1'b0;
				returning_d = 1'b0;
				phase_d = '0;
				step_d = '0;
				target_d = '0;
				dir_d = '0;
				coil_d = '0;
				drivers_d = 1'b0;
				written = 1'b1;
				done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			returning_q <= 1'b0;
			drivers_q <= 1'b0;
			phase_q <= '0;
			step_q <= '0;
			target_q <= '0;
			dir_q <= '0;
			coil_q <= '0;
		end else if (fire) begin
			busy_q <= busy_d;
			returning_q <= returning_d;
			drivers_q <= drivers_d;
			phase_q <= phase_d;
			step_q <= step_d;
			target_q <= target_d;
			dir_q <= dir_d;
			coil_q <= coil_d;
		end
	end

	always_comb begin
		res.coil_pattern = coil_d;
		res.drive_enabled = drivers_d;
		res.pattern_written = written;
		res.running = busy_d;
		res.move_done = done;
	end

endmodule

[src/stp_chk.sv]
// Port-level checks on the stepper sequencer, bound to the top level.
// Depends on stp_pkg.
module stp_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input stp_pkg::coil_t                    coil_pattern,
	input logic                              drive_enabled,
	input logic                              pattern_written,
	input logic                              running,
	input logic                              move_done
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// finishing the return pass releases the coils completely
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && move_done |-> pattern_written && !running && !drive_enabled
			&& coil_pattern == '0)
		else $error("move_done without full release");

	// a move in progress always has the drivers enabled
	a_run_drv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && running |-> drive_enabled)
		else $error("running with drivers off");

	// when idle the coils are not energised
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !running |-> coil_pattern == '0 && !drive_enabled)
		else $error("idle with coils driven");

	// written patterns are half-step entries or the release pattern
	a_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pattern_written |-> $onehot0(coil_pattern) || coil_pattern == 4'd3
			|| coil_pattern == 4'd6 || coil_pattern == 4'd12 || coil_pattern == 4'd9)
		else $error("illegal coil pattern");

endmodule

bind stepper_half_step_round_trip stp_chk u_stp_chk (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.coil_pattern(coil_pattern),
	.drive_enabled(drive_enabled),
	.pattern_written(pattern_written),
	.running(running),
	.move_done(move_done)
);

[dv/tb_stepper_half_step_round_trip.sv]
// Testbench for the half-step stepper sequencer: directed moves, then random tick/start traffic.
// Results are checked against an in-bench motor model with random idling on both channels.
// Depends on stp_pkg and stepper_half_step_round_trip.
module tb_stepper_half_step_round_trip;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic action = stp_pkg::ACT_TICK;
	logic signed [stp_pkg::STEP_W-1:0] step_count = '0;
	logic res_ready = 1'b0;
	logic req_ready;
	logic res_valid;
	stp_pkg::coil_t coil_pattern;
	logic drive_enabled;
	logic pattern_written;
	logic running;
	logic move_done;

	localparam stp_pkg::coil_t HALF_STEP_SEQ [8] =
		'{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

	// motor model state
	logic mot_busy = 1'b0;
	logic mot_returning = 1'b0;
	logic [2:0] mot_phase = '0;
	int unsigned mot_step = 0;
	int unsigned mot_target = 0;
	stp_pkg::dir_t mot_dir = '0;
	stp_pkg::coil_t mot_coil = '0;
	logic mot_drive = 1'b0;

	stp_pkg::res_t expected_results[$];
	int unsigned fail_count = 0;
	bit idle_on = 1'b1;
	int unsigned resp_hold = 0;

	stepper_half_step_round_trip i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.step_count(step_count),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.coil_pattern(coil_pattern),
		.drive_enabled(drive_enabled),
		.pattern_written(pattern_written),
		.running(running),
		.move_done(move_done)
	);

	always #5 clk = ~clk;

	function automatic stp_pkg::res_t next_motor_result(input logic act,
		input logic signed [stp_pkg::STEP_W-1:0] cnt);
		stp_pkg::res_t r;
		int unsigned mag;
		r.pattern_written = 1'b0;
		r.move_done = 1'b0;
		if (act == stp_pkg::ACT_START) begin
			if (!mot_busy) begin
				if (cnt < 0) begin
					mag = 32'h10000 - int'(unsigned'(cnt));
					mot_dir = -2'sd1;
				end else begin
					mag = int'(unsigned'(cnt));
					mot_dir = (cnt != 0) ? 2'sd1 : 2'sd0;
				end
				// counter width is 16, so the 2^16-2 cap never bites
				if (mag > 32'hFFFE)
					mag = 32'hFFFE;
				mot_busy = 1'b1;
				mot_returning = 1'b0;
				mot_step = 0;
				mot_target = mag;
				mot_drive = 1'b1;
			end
		end else if (mot_busy) begin
			if (mot_step <= mot_target) begin
				mot_coil = HALF_STEP_SEQ[mot_phase];
				r.pattern_written = 1'b1;
				case (mot_dir)
					2'sd1: mot_phase = mot_phase + 3'd1;
					-2'sd1: mot_phase = mot_phase - 3'd1;
					default: mot_phase = mot_phase;
				endcase
				mot_step = mot_step + 1;
			end else if (!mot_returning) begin
				// first overrun: turn round without driving
				mot_step = 0;
				mot_phase = '0;
				mot_dir = -mot_dir;
				mot_returning = 1'b1;
			end else begin
				mot_busy = 1'b0;
				mot_returning = 1'b0;
				mot_phase = '0;
				mot_step = 0;
				mot_target = 0;
				mot_dir = '0;
				mot_coil = '0;
				mot_drive = 1'b0;
				r.pattern_written = 1'b1;
				r.move_done = 1'b1;
			end
		end
		r.coil_pattern = mot_coil;
		r.drive_enabled = mot_drive;
		r.running = mot_busy;
		return r;
	endfunction

	task automatic send_request(input logic act, input logic signed [stp_pkg::STEP_W-1:0] cnt);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		step_count <= cnt;
		do @(posedge clk); while (!req_ready);
		expected_results.push_back(next_motor_result(act, cnt));
		@(negedge clk);
	endtask

	task automatic finish_move();
		while (mot_busy)
			send_request(stp_pkg::ACT_TICK, stp_pkg::STEP_W'($urandom));
	endtask

	task automatic test_idle_ticks();
		send_request(stp_pkg::ACT_TICK, 16'sd0);
		send_request(stp_pkg::ACT_TICK, 16'sh7FFF);
		send_request(stp_pkg::ACT_TICK, -16'sd1);
	endtask

	task automatic test_short_moves();
		send_request(stp_pkg::ACT_START, 16'sd3);
		finish_move();
		send_request(stp_pkg::ACT_START, -16'sd5);
		finish_move();
		send_request(stp_pkg::ACT_START, 16'sd1);
		finish_move();
		send_request(stp_pkg::ACT_START, -16'sd1);
		finish_move();
	endtask

	task automatic test_zero_count();
		send_request(stp_pkg::ACT_START, 16'sd0);
		finish_move();
		send_request(stp_pkg::ACT_TICK, 16'sd0);
	endtask

	task automatic test_busy_start();
		send_request(stp_pkg::ACT_START, 16'sd2);
		send_request(stp_pkg::ACT_TICK, 16'sd0);
		send_request(stp_pkg::ACT_START, 16'sh7FFF);
		send_request(stp_pkg::ACT_START, -16'sh8000);
		send_request(stp_pkg::ACT_START, 16'sd0);
		finish_move();
	endtask

	// longer moves in both directions, run without idling
	task automatic test_long_moves();
		idle_on = 1'b0;
		send_request(stp_pkg::ACT_START, 16'sd40);
		finish_move();
		send_request(stp_pkg::ACT_START, -16'sd40);
		finish_move();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned done_items;
		int unsigned mag;
		int unsigned pick;
		logic signed [stp_pkg::STEP_W-1:0] cnt;
		done_items = 0;
		while (done_items < n_items) begin
			if (done_items >= n_items - 100)
				idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (!mot_busy) begin
				if (pick < 12) begin
					send_request(stp_pkg::ACT_TICK, stp_pkg::STEP_W'($urandom));
				end else begin
					pick = $urandom_range(0, 9);
					if (pick < 6)
						mag = $urandom_range(0, 24);
					else if (pick < 9)
						mag = $urandom_range(0, 6);
					else
						mag = $urandom_range(25, 60);
					cnt = $urandom_range(0, 1) ? -stp_pkg::STEP_W'(mag)
						: stp_pkg::STEP_W'(mag);
					send_request(stp_pkg::ACT_START, cnt);
					done_items++;
				end
			end else if (pick < 6) begin
				// start while busy: full-range count, must be ignored
				send_request(stp_pkg::ACT_START, stp_pkg::STEP_W'($urandom));
			end else begin
				send_request(stp_pkg::ACT_TICK, stp_pkg::STEP_W'($urandom));
				done_items++;
			end
		end
		finish_move();
	endtask

	always @(negedge clk) begin
		if (resp_hold > 0) begin
			res_ready <= 1'b0;
			resp_hold = resp_hold - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			res_ready <= 1'b0;
			resp_hold = $urandom_range(0, 11);
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic compare_field(input string fname, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		stp_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %h %b%b%b%b",
					$time, coil_pattern, drive_enabled, pattern_written, running, move_done);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("coil_pattern", want.coil_pattern, coil_pattern);
				compare_field("drive_enabled", want.drive_enabled, drive_enabled);
				compare_field("pattern_written", want.pattern_written, pattern_written);
				compare_field("running", want.running, running);
				compare_field("move_done", want.move_done, move_done);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_ticks();
		test_short_moves();
		test_zero_count();
		test_busy_start();
		test_long_moves();
		test_random_traffic(400);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
src/stp_pkg.sv
src/stp_core.sv
src/stepper_half_step_round_trip.sv
src/stp_chk.sv
dv/tb_stepper_half_step_round_trip.sv
